### hw/rtl/rrts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin task scheduler
// Request codes, run-state codes, table sizes and the front-to-back word.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int MaxTasks   = 16;
	localparam int SignalBits = 32;
	localparam int AlarmBits  = 16;
	localparam int SlotW      = $clog2(MaxTasks);
	localparam int SigW       = 5;
	localparam int QDepth     = 2;

	localparam logic [4:0] SIGALRM = 5'd14;
	localparam logic [SlotW-1:0] IDLE_SLOT = '0;

	localparam logic [2:0] REQ_ADD    = 3'd0;
	localparam logic [2:0] REQ_REMOVE = 3'd1;
	localparam logic [2:0] REQ_TICK   = 3'd2;
	localparam logic [2:0] REQ_SCHED  = 3'd3;
	localparam logic [2:0] REQ_POST   = 3'd4;
	localparam logic [2:0] REQ_SLEEP  = 3'd5;
	localparam logic [2:0] REQ_TAKE   = 3'd6;

	localparam logic [1:0] ST_INIT     = 2'd0;
	localparam logic [1:0] ST_RUNNABLE = 2'd1;
	localparam logic [1:0] ST_RUNNING  = 2'd2;
	localparam logic [1:0] ST_INTR     = 2'd3;

	// classified request word handed from front to back
	typedef struct packed {
		logic [2:0]           req;
		logic [SlotW-1:0]     slot;
		logic                 slot_ok;
		logic [SigW-1:0]      signo;
		logic [AlarmBits-1:0] ticks;
	} cmd_t;

	typedef struct packed {
		logic        push;
	} q_ctl_t;

endpackage
`default_nettype wire

### hw/rtl/rrts_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_front: request intake
// Accept a request, classify it and push it into the command queue.
// ----------------------------------------------------------------------------
module rrts_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [2:0]         req_type,
	input  wire logic [3:0]         target_slot,
	input  wire logic [4:0]         signal_number,
	input  wire logic [15:0]        alarm_ticks,
	input  wire logic               item_open,
	output rrts_pkg::q_ctl_t        qctl,
	output rrts_pkg::cmd_t          cmd,
	output logic                    busy
);

	logic pend_q;

	assign busy = pend_q | item_open;

	always_comb begin
		cmd.req     = req_type;
		cmd.slot    = rrts_pkg::SlotW'(target_slot);
		cmd.slot_ok = 32'(target_slot) < rrts_pkg::MaxTasks;
		cmd.signo   = signal_number;
		cmd.ticks   = rrts_pkg::AlarmBits'(alarm_ticks);
		qctl.push   = start & ~busy;
	end

	// one-cycle accept marker so busy rises with the accepting edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= start & ~busy;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/rrts_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_queue: command queue
// Small FIFO between intake and the slot engine.
// ----------------------------------------------------------------------------
module rrts_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rrts_pkg::q_ctl_t qctl,
	input  wire rrts_pkg::cmd_t in_cmd,
	input  wire logic           pop,
	output logic                not_empty,
	output rrts_pkg::cmd_t      out_cmd
);

	localparam int PW = $clog2(rrts_pkg::QDepth);

	rrts_pkg::cmd_t   mem_q [rrts_pkg::QDepth];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;

	assign not_empty = cnt_q != '0;
	assign out_cmd   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (qctl.push) begin
			mem_q[wp_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (qctl.push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(qctl.push) - (PW+1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.push |-> (cnt_q < (PW+1)'(rrts_pkg::QDepth)))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue underflow");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(rrts_pkg::QDepth))
		else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

### hw/rtl/rrts_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_engine: slot engine
// Carry out one command over the slot table, one slot per cycle for walks.
// ----------------------------------------------------------------------------
module rrts_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire rrts_pkg::cmd_t cmd,
	input  wire logic [4:0]     alarm_sig,
	output logic                pop,
	output logic                active,
	output logic                done,
	output logic [3:0]          running_slot,
	output logic                switched,
	output logic                signal_valid,
	output logic [4:0]          taken_signal,
	output logic                error_flag
);

	localparam int SW = rrts_pkg::SlotW;
	localparam int NB = rrts_pkg::SignalBits;
	localparam int AB = rrts_pkg::AlarmBits;
	localparam int SigW_t = rrts_pkg::SigW;

	localparam logic [1:0] E_IDLE = 2'd0;
	localparam logic [1:0] E_TICK = 2'd1;
	localparam logic [1:0] E_SCAN = 2'd2;

	logic [1:0]    st_q;
	logic [rrts_pkg::MaxTasks-1:0] act_q;
	logic [1:0]    run_q [rrts_pkg::MaxTasks];
	logic [AB-1:0] alm_q [rrts_pkg::MaxTasks];
	logic [NB-1:0] sig_q [rrts_pkg::MaxTasks];
	logic [SW-1:0] cur_q, idx_q;
	logic [SW:0]   cnt_q;

	logic [NB-1:0] cur_sig;
	logic [NB-1:0] alarm_bit, post_bit;
	logic [SigW_t-1:0] low_n;
	logic          low_any;
	logic [AB-1:0] dec;
	logic [NB-1:0] nsig;

	assign cur_sig = sig_q[cur_q];
	assign alarm_bit = (32'(alarm_sig) < NB) ? (NB'(1) << alarm_sig) : '0;
	assign post_bit  = (32'(cmd.signo) < NB) ? (NB'(1) << cmd.signo) : '0;
	assign pop    = cmd_valid & (st_q == E_IDLE);
	assign active = st_q != E_IDLE;
	assign running_slot = 4'(cur_q);

	always_comb begin
		low_n   = '0;
		low_any = 1'b0;
		for (int b = NB - 1; b >= 0; b--) begin
			if (cur_sig[b]) begin
				low_n   = SigW_t'(b);
				low_any = 1'b1;
			end
		end
		dec  = alm_q[idx_q] - 1'b1;
		nsig = sig_q[idx_q] | ((alm_q[idx_q] == AB'(1)) ? alarm_bit : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= E_IDLE;
			act_q <= '0;
			cur_q <= rrts_pkg::IDLE_SLOT;
			idx_q <= '0;
			cnt_q <= '0;
			done  <= 1'b0;
			switched <= 1'b0;
			signal_valid <= 1'b0;
			taken_signal <= '0;
			error_flag <= 1'b0;
			for (int s = 0; s < rrts_pkg::MaxTasks; s++) begin
				run_q[s] <= rrts_pkg::ST_INIT;
				alm_q[s] <= '0;
				sig_q[s] <= '0;
			end
		end else begin
			done <= 1'b0;
			unique case (st_q)
				E_IDLE: begin
					if (cmd_valid) begin
						switched     <= 1'b0;
						signal_valid <= 1'b0;
						taken_signal <= '0;
						error_flag   <= 1'b0;
						done         <= 1'b1;
						unique case (cmd.req)
							rrts_pkg::REQ_ADD: begin
								if (cmd.slot_ok) begin
									if (act_q[cmd.slot]) begin
										error_flag <= 1'b1;
									end else begin
										act_q[cmd.slot] <= 1'b1;
										run_q[cmd.slot] <= rrts_pkg::ST_RUNNABLE;
										alm_q[cmd.slot] <= '0;
										sig_q[cmd.slot] <= '0;
									end
								end
							end
							rrts_pkg::REQ_REMOVE: begin
								if (cmd.slot == rrts_pkg::IDLE_SLOT) begin
									error_flag <= 1'b1;
								end else if (cmd.slot_ok) begin
									act_q[cmd.slot] <= 1'b0;
									run_q[cmd.slot] <= rrts_pkg::ST_INIT;
									alm_q[cmd.slot] <= '0;
									sig_q[cmd.slot] <= '0;
								end
							end
							rrts_pkg::REQ_TICK: begin
								done  <= 1'b0;
								idx_q <= SW'(1);
								st_q  <= E_TICK;
							end
							rrts_pkg::REQ_SCHED: begin
								if (cur_sig == '0) begin
									done  <= 1'b0;
									if (act_q[cur_q] && run_q[cur_q] == rrts_pkg::ST_RUNNING) begin
										run_q[cur_q] <= rrts_pkg::ST_RUNNABLE;
									end
									idx_q <= cur_q + 1'b1;
									cnt_q <= '0;
									st_q  <= E_SCAN;
								end
							end
							rrts_pkg::REQ_POST: begin
								if (cmd.slot_ok && act_q[cmd.slot]) begin
									sig_q[cmd.slot] <= sig_q[cmd.slot] | post_bit;
								end
							end
							rrts_pkg::REQ_SLEEP: begin
								if (cur_q == rrts_pkg::IDLE_SLOT) begin
									error_flag <= 1'b1;
								end else if (act_q[cur_q]) begin
									alm_q[cur_q] <= cmd.ticks;
									run_q[cur_q] <= rrts_pkg::ST_INTR;
								end
							end
							rrts_pkg::REQ_TAKE: begin
								if (low_any) begin
									sig_q[cur_q] <= cur_sig & ~(NB'(1) << low_n);
									signal_valid <= 1'b1;
									taken_signal <= 5'(low_n);
								end
							end
							default: begin
							end
						endcase
					end
				end
				E_TICK: begin
					// advance one slot per cycle
					if (act_q[idx_q] && run_q[idx_q] != rrts_pkg::ST_INIT) begin
						if (alm_q[idx_q] != '0) begin
							alm_q[idx_q] <= dec;
							sig_q[idx_q] <= nsig;
						end
						if (((alm_q[idx_q] != '0) ? nsig : sig_q[idx_q]) != '0
							&& run_q[idx_q] == rrts_pkg::ST_INTR) begin
							run_q[idx_q] <= rrts_pkg::ST_RUNNABLE;
						end
					end
					if (32'(idx_q) == rrts_pkg::MaxTasks - 1) begin
						st_q <= E_IDLE;
						done <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
				end
				E_SCAN: begin
					if (idx_q != rrts_pkg::IDLE_SLOT && act_q[idx_q]
						&& run_q[idx_q] == rrts_pkg::ST_RUNNABLE) begin
						run_q[idx_q] <= rrts_pkg::ST_RUNNING;
						switched <= idx_q != cur_q;
						cur_q <= idx_q;
						st_q  <= E_IDLE;
						done  <= 1'b1;
					end else if (32'(cnt_q) == rrts_pkg::MaxTasks - 1) begin
						switched <= cur_q != rrts_pkg::IDLE_SLOT;
						cur_q <= rrts_pkg::IDLE_SLOT;
						st_q  <= E_IDLE;
						done  <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					cnt_q <= cnt_q + 1'b1;
				end
				default: begin
					st_q <= E_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_idle_not_running: assert property (@(posedge clk) disable iff (!arst_n)
		run_q[rrts_pkg::IDLE_SLOT] != rrts_pkg::ST_RUNNING)
		else $error("idle slot marked running");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (done || active))
		else $error("command popped without progress");
	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(done && signal_valid) |-> $past(low_any))
		else $error("signal taken from empty set");
`endif

endmodule
`default_nettype wire

### hw/rtl/round_robin_task_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_task_scheduler: hardware round-robin task scheduler
// Sixteen task slots with signals, alarms and an idle task in slot 0.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_type, target_slot, signal_number and
//   alarm_ticks with start high; the word is taken at an edge where busy
//   is low. busy then stays high until the result has been shown.
//   Result channel: done pulses for one cycle with running_slot, switched,
//   signal_valid, taken_signal and error_flag. The receiver cannot stall;
//   it must take the word in that cycle.
//   Config channel: cfg_valid/cfg_ready write alarm_signal; cfg_ready is
//   always high. Write only while busy is low.
// Sequencing and throughput:
//   Add, remove, post, sleep and take are queued, popped by the idle engine
//   and answered with a registered done. Tick walks slots 1..15 one per cycle
//   in the slot engine. Schedule walks up to 16 slots from the current one,
//   or none when the current task has a signal pending. A new word is taken
//   no sooner than the cycle after done, so the engine's walk sets the rate.
// Reset: arst_n clears every slot, sets the current task to idle and
//   restores alarm_signal to 14.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  req_type,
	input  wire logic [3:0]  target_slot,
	input  wire logic [4:0]  signal_number,
	input  wire logic [15:0] alarm_ticks,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [4:0]  cfg_data,
	output logic             done,
	output logic [3:0]       running_slot,
	output logic             switched,
	output logic             signal_valid,
	output logic [4:0]       taken_signal,
	output logic             error_flag
);

	rrts_pkg::q_ctl_t qctl;
	rrts_pkg::cmd_t   f_cmd, q_cmd;
	logic             q_ne, pop, eng_active;
	logic             open_q;
	logic [4:0]       alarm_sig_q;

	// hold the config register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_sig_q <= rrts_pkg::SIGALRM;
		end else if (cfg_valid && cfg_ready) begin
			alarm_sig_q <= cfg_data;
		end
	end

	// an item stays open from the queue push until its result word drops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (qctl.push) begin
			open_q <= 1'b1;
		end else if (done) begin
			open_q <= 1'b0;
		end
	end

	rrts_front u_front (
		.clk, .arst_n, .start, .req_type, .target_slot, .signal_number,
		.alarm_ticks,
		.item_open (open_q | q_ne | eng_active),
		.qctl, .cmd (f_cmd), .busy
	);

	rrts_queue u_queue (
		.clk, .arst_n, .qctl, .in_cmd (f_cmd), .pop,
		.not_empty (q_ne), .out_cmd (q_cmd)
	);

	rrts_engine u_engine (
		.clk, .arst_n, .cmd_valid (q_ne), .cmd (q_cmd), .alarm_sig (alarm_sig_q),
		.pop, .active (eng_active), .done, .running_slot, .switched,
		.signal_valid, .taken_signal, .error_flag
	);

`ifndef SYNTHESIS
	a_busy_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy did not rise after accept");
	a_done_needs_open: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> open_q)
		else $error("result word without open item");
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result words");
`endif

endmodule
`default_nettype wire
